>>> hw/rtl/sxd_pkg.sv
// ----------------------------------------------------------------------------
// sxd_pkg
// Shared types and constants for the XOR sprite draw block: the opcodes, the
// sprite and output row widths, and the command bundle that the controller
// sends to the datapath.
// ----------------------------------------------------------------------------
package sxd_pkg;

  // Opcodes of an input request.
  localparam logic OP_DRAW = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Pixels in one sprite row and bits in one output row.
  localparam int SPRITE_W = 8;
  localparam int OUT_W    = 64;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture the accepted request
    logic rd;    // read the addressed framebuffer row
    logic upd;   // merge the sprite, write back, and register the result
  } sxd_cmd_t;

endpackage

>>> hw/rtl/sxd_ctrl.sv
// ----------------------------------------------------------------------------
// sxd_ctrl
// Controller state machine. It steps each accepted request through a row
// read, an update and an output stage, and drives both handshakes.
// ----------------------------------------------------------------------------
module sxd_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output sxd_pkg::sxd_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Handshake outputs follow directly from the state.
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  // A new request is never taken while a result is still on offer.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while a result is pending");

  // An accepted request is followed by the row read.
  a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> cmd.rd)
    else $error("accepted request was not followed by a row read");

  // The update always presents a result in the next cycle.
  a_upd_presents: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd |=> out_valid)
    else $error("update was not followed by a valid result");
`endif

endmodule

>>> hw/rtl/sxd_dpath.sv
// ----------------------------------------------------------------------------
// sxd_dpath
// Datapath: coordinate wrapping, the framebuffer memory with per-row valid
// bits, the sprite XOR merge, the collision accumulator and the result
// registers.
// ----------------------------------------------------------------------------
module sxd_dpath #(
  parameter int SCREEN_W = 64,
  parameter int SCREEN_H = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sxd_pkg::sxd_cmd_t cmd,
  input  logic              in_opcode,
  input  logic [7:0]        in_start_x,
  input  logic [7:0]        in_start_y,
  input  logic [3:0]        in_row_offset,
  input  logic [7:0]        in_sprite_bits,
  input  logic              in_first_row,
  input  logic              in_last_row,
  output logic [63:0]       out_row_pixels,
  output logic              out_collision,
  output logic              out_sprite_done
);

  localparam int XW  = $clog2(SCREEN_W);
  localparam int YW  = $clog2(SCREEN_H);
  localparam int YSW = ((YW > 4) ? YW : 4) + 1;
  localparam int SW  = sxd_pkg::SPRITE_W;
  localparam int OW  = sxd_pkg::OUT_W;

  // Wrap tables for the 8-bit start coordinates.
  logic [XW-1:0] xmod_tab [256];
  logic [YW-1:0] ymod_tab [256];

  for (genvar g = 0; g < 256; g++) begin : g_wrap
    localparam int XM = g % SCREEN_W;
    localparam int YM = g % SCREEN_H;
    assign xmod_tab[g] = XW'(XM);
    assign ymod_tab[g] = YW'(YM);
  end

  // Captured request.
  logic          op_r;
  logic [XW-1:0] x0_r;
  logic [YSW-1:0] ysum_r;
  logic [SW-1:0] bits_r;
  logic          first_r;
  logic          last_r;

  // Framebuffer memory; rows never written read as all off.
  logic [SCREEN_W-1:0] frame_r [SCREEN_H];
  logic [SCREEN_H-1:0] vld_r;
  logic [SCREEN_W-1:0] rd_row_r;
  logic                rd_vld_r;

  // Collision accumulator.
  logic acc_r;
  logic acc_nxt;

  logic [YSW-1:0]      ysum_in;
  logic [YW-1:0]       addr;
  logic                in_range;
  logic                draw;
  logic [SCREEN_W-1:0] cur_row;
  logic [SCREEN_W+SW-1:0] mask_ext;
  logic [SCREEN_W-1:0] mask;
  logic [SCREEN_W-1:0] new_row;
  logic                hit;
  logic [SCREEN_W-1:0] row_res;
  logic [OW-1:0]       row_wide;

  // A draw addresses start row plus offset; a read addresses the start row.
  assign ysum_in = (in_opcode == sxd_pkg::OP_DRAW)
                 ? (YSW'(ymod_tab[in_start_y]) + YSW'(in_row_offset))
                 : YSW'(ymod_tab[in_start_y]);

  // Capture the request at acceptance.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_opcode;
      x0_r    <= xmod_tab[in_start_x];
      ysum_r  <= ysum_in;
      bits_r  <= in_sprite_bits;
      first_r <= in_first_row;
      last_r  <= in_last_row;
    end
  end

  assign addr     = ysum_r[YW-1:0];
  assign in_range = (ysum_r < YSW'(SCREEN_H));
  assign draw     = (op_r == sxd_pkg::OP_DRAW);

  // Sprite mask: column 0 is the row's top bit; pixels past the edge drop off.
  assign mask_ext = {bits_r, {SCREEN_W{1'b0}}} >> x0_r;
  assign mask     = mask_ext[SCREEN_W+SW-1:SW];

  assign cur_row = rd_vld_r ? rd_row_r : '0;
  assign new_row = cur_row ^ mask;
  assign hit     = |(cur_row & mask);

  // The accumulator clears on a first row and sets when a lit pixel goes off.
  always_comb begin
    acc_nxt = acc_r;
    if (draw) begin
      acc_nxt = (first_r ? 1'b0 : acc_r) | (in_range & hit);
    end
  end

  always_comb begin
    if (draw) begin
      row_res = in_range ? new_row : '0;
    end else begin
      row_res = cur_row;
    end
  end

  // Align the row to the 64-bit output with column 0 at the top bit.
  if (SCREEN_W >= OW) begin : g_out_trunc
    assign row_wide = row_res[SCREEN_W-1 -: OW];
  end else begin : g_out_pad
    assign row_wide = {row_res, {(OW-SCREEN_W){1'b0}}};
  end

  // Memory read and write-back.
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_row_r <= frame_r[addr];
    end
    if (cmd.upd && draw && in_range) begin
      frame_r[addr] <= new_row;
    end
  end

  // Row valid bits and the accumulator.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
      acc_r    <= 1'b0;
    end else begin
      if (cmd.rd) begin
        rd_vld_r <= in_range & vld_r[addr];
      end
      if (cmd.upd) begin
        acc_r <= acc_nxt;
        if (draw && in_range) begin
          vld_r[addr] <= 1'b1;
        end
      end
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      out_row_pixels  <= row_wide;
      out_collision   <= acc_nxt;
      out_sprite_done <= draw & last_r;
    end
  end

`ifndef SYNTHESIS
  // A draw below the bottom edge reports an empty row.
  a_clip_row: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.upd && draw && !in_range) |=> (out_row_pixels == '0))
    else $error("clipped draw reported a nonzero row");

  // A read leaves the collision accumulator alone.
  a_read_keeps_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.upd && !draw) |=> $stable(acc_r))
    else $error("read request changed the collision accumulator");
`endif

endmodule

>>> hw/rtl/sprite_xor_draw_collision.sv
// ----------------------------------------------------------------------------
// sprite_xor_draw_collision
// Framebuffer of SCREEN_W x SCREEN_H one-bit pixels. A draw request XORs one
// 8-pixel sprite row into it with clipping and collision tracking; a read
// request returns one row.
// ----------------------------------------------------------------------------
// The request is captured, its row read, then merged and registered; a new
// one is taken only once out_ready takes the result. Each request reads the
// framebuffer once; an on-screen draw writes back once, on one memory port.
// Reset: synchronous on rst_n; control state, the per-row valid bits and the
// collision flag clear at once, so the framebuffer reads as all off with no
// clearing pass.
// ----------------------------------------------------------------------------
module sprite_xor_draw_collision #(
  parameter int SCREEN_W = 64,
  parameter int SCREEN_H = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [7:0]  in_start_x,
  input  logic [7:0]  in_start_y,
  input  logic [3:0]  in_row_offset,
  input  logic [7:0]  in_sprite_bits,
  input  logic        in_first_row,
  input  logic        in_last_row,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_row_pixels,
  output logic        out_collision,
  output logic        out_sprite_done
);

  sxd_pkg::sxd_cmd_t cmd;

  // Request sequencing.
  sxd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Framebuffer, sprite merge and result registers.
  sxd_dpath #(
    .SCREEN_W (SCREEN_W),
    .SCREEN_H (SCREEN_H)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_opcode       (in_opcode),
    .in_start_x      (in_start_x),
    .in_start_y      (in_start_y),
    .in_row_offset   (in_row_offset),
    .in_sprite_bits  (in_sprite_bits),
    .in_first_row    (in_first_row),
    .in_last_row     (in_last_row),
    .out_row_pixels  (out_row_pixels),
    .out_collision   (out_collision),
    .out_sprite_done (out_sprite_done)
  );

endmodule
